/* rtl/etr_pkg.sv */
// ----------------------------------------------------------------------------
// etr_pkg: shared types and constants
// Fixed widths, saturation limits and the sequencer states of the Taylor
// series exponential block.
// ----------------------------------------------------------------------------
`default_nettype none

package etr_pkg;

  localparam int unsigned X_W       = 32;
  localparam int unsigned MAG_W     = 48;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CELL_BITS = 6;
  localparam int unsigned NCELL     = MAG_W / CELL_BITS;

  localparam logic [MAG_W-1:0] VAL_ONE = 48'h0001_0000_0000;
  localparam logic [MAG_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0] SAT_NEG = 48'h8000_0000_0000;
  localparam logic [CFG_W-1:0] CFG_RST = 6'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_RND,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } etr_state_e;

endpackage

`default_nettype wire

/* rtl/etr_div_cell.sv */
// ----------------------------------------------------------------------------
// etr_div_cell: one cell of the divider chain
// Takes CELL_BITS restoring division steps on a small divisor and hands the
// partial remainder, shifted word and sign to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_div_cell #(
  parameter int unsigned DW = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        neg_i,
  input  logic [DW-1:0]               div_i,
  input  logic [DW-1:0]               rem_i,
  input  logic [etr_pkg::MAG_W-1:0]   word_i,
  output logic                        valid_o,
  output logic                        neg_o,
  output logic [DW-1:0]               div_o,
  output logic [DW-1:0]               rem_o,
  output logic [etr_pkg::MAG_W-1:0]   word_o
);
  import etr_pkg::*;

  logic [DW:0]      rem_w;
  logic [MAG_W-1:0] word_w;
  logic [DW-1:0]    rem_n;
  logic [MAG_W-1:0] word_n;

  always_comb begin
    rem_n  = rem_i;
    word_n = word_i;
    rem_w  = '0;
    word_w = '0;
    for (int k = 0; k < int'(CELL_BITS); k++) begin
      rem_w  = {rem_n, word_n[MAG_W-1]};
      word_w = {word_n[MAG_W-2:0], 1'b0};
      if (rem_w >= {1'b0, div_i}) begin
        rem_w     = rem_w - {1'b0, div_i};
        word_w[0] = 1'b1;
      end
      rem_n  = rem_w[DW-1:0];
      word_n = word_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_o  <= neg_i;
    div_o  <= div_i;
    rem_o  <= rem_n;
    word_o <= word_n;
  end

endmodule

`default_nettype wire

/* rtl/exp_taylor_running_term.sv */
// ----------------------------------------------------------------------------
// exp_taylor_running_term: truncated Taylor series for e^x
// Sums 1 + x/1! + ... + x^n/n! in Q16.32 with a running term, saturating on
// overflow of the term or the sum.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields
//  s_axis    in   tdata: x_value[31:0]
//  m_axis    out  tdata: exp_sum[47:0]; tuser: overflow
//  cfg       in   cfg_data_i: term_count[5:0]
//
//  Requests are handled one at a time; each of up to n terms is multiplied by
//  x, rounded, divided by its index in the eight-cell divider chain and added
//  to the sum. Reset is asynchronous and active low; it sets term_count to 8
//  and empties the pipeline. A stalled result waits in the output register
//  while the next request is taken.
`default_nettype none

module exp_taylor_running_term #(
  parameter int unsigned TERMS_MAX   = 32,
  parameter int unsigned X_FRAC_BITS = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // x_value[31:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [47:0]                m_axis_tdata,  // exp_sum[47:0]
  output logic                       m_axis_tuser,  // overflow
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [etr_pkg::CFG_W-1:0]  cfg_data_i
);
  import etr_pkg::*;

  localparam int unsigned CW  = $clog2(TERMS_MAX + 2);
  localparam int unsigned DW  = $clog2(TERMS_MAX + 1);
  localparam int unsigned PW  = MAG_W + X_W;
  localparam int unsigned QFW = PW - X_FRAC_BITS;
  localparam logic [QFW:0] LIM_POS = (QFW+1)'(SAT_POS);
  localparam logic [QFW:0] LIM_NEG = (QFW+1)'(SAT_NEG);

  etr_state_e state_q, state_d;

  logic [CFG_W-1:0] cfg_q;
  logic             xneg_q;
  logic [X_W-1:0]   xmag_q;
  logic [MAG_W-1:0] term_q;
  logic [MAG_W-1:0] sum_q;
  logic             ovf_q;
  logic [CW-1:0]    i_q;
  logic [CW-1:0]    n_q;
  logic [63:0]      plo_q;
  logic [MAG_W-1:0] phi_q;
  logic             ld_vld_q;
  logic             ld_neg_q;
  logic [MAG_W-1:0] ld_mag_q;
  logic             out_vld_q;
  logic [MAG_W-1:0] out_sum_q;
  logic             out_ovf_q;

  logic [MAG_W-1:0] tmag;
  logic [PW-1:0]    prod;
  logic [QFW:0]     qq;
  logic             mneg;
  logic             rem_nz;
  logic             movf;
  logic [MAG_W-1:0] dq;
  logic [MAG_W-1:0] dterm;
  logic [MAG_W:0]   s;
  logic             sovf;
  logic [CW-1:0]    n_new;
  logic             out_free;

  logic             c_vld  [0:NCELL];
  logic             c_neg  [0:NCELL];
  logic [DW-1:0]    c_div  [0:NCELL];
  logic [DW-1:0]    c_rem  [0:NCELL];
  logic [MAG_W-1:0] c_word [0:NCELL];

  assign c_vld[0]  = ld_vld_q;
  assign c_neg[0]  = ld_neg_q;
  assign c_div[0]  = DW'(i_q);
  assign c_rem[0]  = '0;
  assign c_word[0] = ld_mag_q;

  for (genvar g = 0; g < int'(NCELL); g++) begin : g_cell
    etr_div_cell #(.DW(DW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_vld[g]),
      .neg_i   (c_neg[g]),
      .div_i   (c_div[g]),
      .rem_i   (c_rem[g]),
      .word_i  (c_word[g]),
      .valid_o (c_vld[g+1]),
      .neg_o   (c_neg[g+1]),
      .div_o   (c_div[g+1]),
      .rem_o   (c_rem[g+1]),
      .word_o  (c_word[g+1])
    );
  end

  always_comb begin
    tmag   = term_q[MAG_W-1] ? (~term_q + 1'b1) : term_q;
    prod   = {phi_q, 32'b0} + {16'b0, plo_q};
    mneg   = term_q[MAG_W-1] ^ xneg_q;
    rem_nz = |prod[X_FRAC_BITS-1:0];
    qq     = {1'b0, prod[PW-1:X_FRAC_BITS]} + (QFW+1)'(mneg && rem_nz);
    movf   = mneg ? (qq > LIM_NEG) : (qq > LIM_POS);
    dq     = c_word[NCELL] + MAG_W'(c_neg[NCELL] && (c_rem[NCELL] != '0));
    dterm  = c_neg[NCELL] ? (~dq + 1'b1) : dq;
    s      = {sum_q[MAG_W-1], sum_q} + {term_q[MAG_W-1], term_q};
    sovf   = s[MAG_W] ^ s[MAG_W-1];
    n_new  = (int'(cfg_q) > int'(TERMS_MAX)) ? CW'(TERMS_MAX) : CW'(cfg_q);
    out_free = !out_vld_q || m_axis_tready;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_CHECK;
      ST_CHECK: state_d = (i_q > n_q || term_q == '0) ? ST_OUT : ST_MUL;
      ST_MUL:   state_d = ST_RND;
      ST_RND:   state_d = movf ? ST_OUT : ST_DIV;
      ST_DIV:   if (c_vld[NCELL]) state_d = ST_ACC;
      ST_ACC:   state_d = sovf ? ST_OUT : ST_CHECK;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    cfg_ready_o   = 1'b1;
    m_axis_tvalid = out_vld_q;
    m_axis_tdata  = out_sum_q;
    m_axis_tuser  = out_ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CFG_RST;
      ld_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ld_vld_q <= (state_q == ST_RND) && !movf;
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        xneg_q <= s_axis_tdata[X_W-1];
        xmag_q <= s_axis_tdata[X_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
        term_q <= VAL_ONE;
        sum_q  <= VAL_ONE;
        ovf_q  <= 1'b0;
        i_q    <= CW'(1);
        n_q    <= n_new;
      end
      ST_MUL: begin
        plo_q <= tmag[31:0] * xmag_q;
        phi_q <= tmag[MAG_W-1:32] * xmag_q;
      end
      ST_RND: begin
        if (movf) begin
          sum_q <= mneg ? SAT_NEG : SAT_POS;
          ovf_q <= 1'b1;
        end
        ld_neg_q <= mneg;
        ld_mag_q <= qq[MAG_W-1:0];
      end
      ST_DIV: begin
        if (c_vld[NCELL]) begin
          term_q <= dterm;
        end
      end
      ST_ACC: begin
        if (sovf) begin
          sum_q <= s[MAG_W] ? SAT_NEG : SAT_POS;
          ovf_q <= 1'b1;
        end else begin
          sum_q <= s[MAG_W-1:0];
        end
        i_q <= i_q + 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_sum_q <= sum_q;
          out_ovf_q <= ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/etr_checker.sv */
// ----------------------------------------------------------------------------
// etr_checker: port-level checks
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled result changed.");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == 48'h7FFF_FFFF_FFFF) || (m_axis_tdata == 48'h8000_0000_0000))
    else $error("Overflow flagged without a saturated sum.");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input ready while a request is in progress.");

endmodule

bind exp_taylor_running_term etr_checker u_etr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
